// ===== sv/rbd_pkg.sv =====
// shared constants, types and helpers for the rgba 2x2 box downsampler
`default_nettype none
package rbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  localparam int DIM_W      = 13;   // configured dimension
  localparam int POS_W      = 12;   // column / row position
  localparam int CH_W       = 8;    // one color channel
  localparam int PAIR_W     = CH_W + 1;
  localparam int LSUM_W     = 10;   // stored pair sum per channel
  localparam int NUM_CH     = 4;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int LINE_W     = NUM_CH * LSUM_W;
  localparam int CFG_AW     = 1;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [DIM_W-1:0] dim_t;

  // derived per-dimension limits, kept in registers
  typedef struct packed {
    logic one;   // dimension is a single pixel
    pos_t last;  // dim - 1
    pos_t pend;  // last position of the last full pair
  } dim_lim_t;

  function automatic dim_t clamp_dim(input dim_t v, input dim_t max_v);
    dim_t r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > max_v) r = max_v;
    return r;
  endfunction

  function automatic dim_lim_t make_lim(input dim_t v, input dim_t max_v);
    dim_t     c;
    dim_lim_t l;
    c      = clamp_dim(v, max_v);
    l.one  = (c == DIM_W'(1));
    l.last = POS_W'(c - DIM_W'(1));
    l.pend = POS_W'((c & ~DIM_W'(1)) - DIM_W'(1));
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rbd_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module rbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/rgba_box_downsample_2x2_core.sv =====
// top level of the rgba 2x2 box-filter downsampler
//
//  channel | dir | handshake          | content
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_tvalid/tready   | one rgba8 source pixel, raster order
//  out_    | out | out_tvalid/tready  | one averaged pixel, tlast=row end, tuser=image end
//  cfg_    | in  | cfg_we             | image_width (index 0), image_height (index 1)
//
// one source pixel per clock unless a stalled out_ side holds both registers; the line
// buffer has one write and one read port and a pixel uses at most one of them, so
// memory latency never stalls the input; a result passes stage 1 then the output register
// reset (synchronous, rst_n low): image restarts, size returns to 2x2
// a config write also restarts the image at column 0, row 0
// a stalled out_ side backs up through one compute stage, then drops in_tready
`default_nettype none
module rgba_box_downsample_2x2_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // source pixels
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [rbd_pkg::PIX_W-1:0]    in_tdata,   // red, green, blue, alpha
  // downsampled pixels
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [rbd_pkg::PIX_W-1:0]    out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                              out_tlast,  // row_end
  output logic      [0:0]                   out_tuser,  // image_end
  // configuration writes
  input  wire logic                         cfg_we,
  input  wire logic [rbd_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [rbd_pkg::DIM_W-1:0]    cfg_wdata
);

  localparam int CH   = rbd_pkg::NUM_CH;
  localparam int CW   = rbd_pkg::CH_W;
  localparam int PW   = rbd_pkg::PAIR_W;
  localparam int LW   = rbd_pkg::LSUM_W;
  localparam int AW   = rbd_pkg::LINE_AW;

  // --------------------------------------------------------------------------
  // configuration: clamped size kept as derived limits
  // --------------------------------------------------------------------------
  rbd_pkg::dim_lim_t wlim_r, wlim_nxt;
  rbd_pkg::dim_lim_t hlim_r, hlim_nxt;
  logic              cfg_hit;

  always_comb begin
    wlim_nxt = wlim_r;
    hlim_nxt = hlim_r;
    cfg_hit  = 1'b0;
    if (cfg_we) begin
      case (cfg_addr)
        rbd_pkg::REG_IMAGE_WIDTH: begin
          wlim_nxt = rbd_pkg::make_lim(cfg_wdata, rbd_pkg::DIM_W'(rbd_pkg::MAX_WIDTH));
          cfg_hit  = 1'b1;
        end
        rbd_pkg::REG_IMAGE_HEIGHT: begin
          hlim_nxt = rbd_pkg::make_lim(cfg_wdata, rbd_pkg::DIM_W'(rbd_pkg::MAX_HEIGHT));
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;   // unknown index is ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: position tracking, pair forming, line buffer access
  // --------------------------------------------------------------------------
  rbd_pkg::pos_t          x_r, x_nxt;
  rbd_pkg::pos_t          y_r, y_nxt;
  logic [rbd_pkg::PIX_W-1:0] held_r;

  logic                   in_xfer;
  logic                   col_in, row_in;
  logic                   have_pair, last_col, last_row;
  logic                   line_wr, line_rd, emit, dbl_row;
  logic [CH*PW-1:0]       pair;
  logic [AW-1:0]          idx;
  logic [rbd_pkg::LINE_W-1:0] line_wdata, line_rdata;

  assign in_xfer = in_tvalid && in_tready;

  always_comb begin
    col_in    = (x_r <= wlim_r.pend);
    row_in    = (y_r <= hlim_r.pend);
    have_pair = wlim_r.one || (col_in && x_r[0]);
    last_col  = wlim_r.one || (x_r == wlim_r.pend);
    last_row  = hlim_r.one || (y_r == hlim_r.pend);
    idx       = wlim_r.one ? '0 : x_r[rbd_pkg::POS_W-1:1];
    for (int c = 0; c < CH; c++) begin
      // a single column counts its pixel twice
      if (wlim_r.one) begin
        pair[c*PW +: PW] = {in_tdata[c*CW +: CW], 1'b0};
      end else begin
        pair[c*PW +: PW] = PW'(held_r[c*CW +: CW]) + PW'(in_tdata[c*CW +: CW]);
      end
      line_wdata[c*LW +: LW] = LW'(pair[c*PW +: PW]);
    end
    // upper row of a block pair stores, lower row reads back; one row doubles
    dbl_row = hlim_r.one;
    line_wr = in_xfer && have_pair && !hlim_r.one && row_in && !y_r[0];
    line_rd = in_xfer && have_pair && !hlim_r.one && row_in && y_r[0];
    emit    = in_xfer && have_pair && (hlim_r.one || (row_in && y_r[0]));
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (cfg_hit) begin
      x_nxt = '0;
      y_nxt = '0;
    end else if (in_xfer) begin
      if (x_r == wlim_r.last) begin
        x_nxt = '0;
        y_nxt = (y_r == hlim_r.last) ? '0 : y_r + rbd_pkg::POS_W'(1);
      end else begin
        x_nxt = x_r + rbd_pkg::POS_W'(1);
      end
    end
  end

  // an entry is read one full source row after it was written, so a read never
  // meets a write to the same entry in flight
  rbd_ram #(
    .WIDTH (rbd_pkg::LINE_W),
    .DEPTH (rbd_pkg::LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_wr),
    .waddr (idx),
    .wdata (line_wdata),
    .re    (line_rd),
    .raddr (idx),
    .rdata (line_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: vertical sum and rounding; stage 2: output register
  // --------------------------------------------------------------------------
  logic                   s1_valid_r;
  logic                   s1_dbl_r, s1_last_col_r, s1_last_row_r;
  logic [CH*PW-1:0]       s1_pair_r;
  logic                   s1_adv;
  logic [rbd_pkg::PIX_W-1:0] avg;
  logic [LW:0]            sum_rnd;

  logic                   out_valid_r;
  logic [rbd_pkg::PIX_W-1:0] out_data_r;
  logic                   out_row_end_r, out_img_end_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;

  always_comb begin
    sum_rnd = '0;
    avg     = '0;
    for (int c = 0; c < CH; c++) begin
      if (s1_dbl_r) begin
        sum_rnd = (LW+1)'({s1_pair_r[c*PW +: PW], 1'b0}) + (LW+1)'(2);
      end else begin
        sum_rnd = (LW+1)'(line_rdata[c*LW +: LW]) + (LW+1)'(s1_pair_r[c*PW +: PW])
                + (LW+1)'(2);
      end
      avg[c*CW +: CW] = sum_rnd[2 +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlim_r      <= rbd_pkg::make_lim(rbd_pkg::DIM_W'(2), rbd_pkg::DIM_W'(rbd_pkg::MAX_WIDTH));
      hlim_r      <= rbd_pkg::make_lim(rbd_pkg::DIM_W'(2), rbd_pkg::DIM_W'(rbd_pkg::MAX_HEIGHT));
      x_r         <= '0;
      y_r         <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wlim_r <= wlim_nxt;
      hlim_r <= hlim_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      if (emit) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer && !wlim_r.one && col_in && !x_r[0]) begin
      held_r <= in_tdata;          // left pixel of the pair
    end
    if (emit) begin
      s1_pair_r     <= pair;
      s1_dbl_r      <= dbl_row;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
    end
    if (s1_adv) begin
      out_data_r    <= avg;
      out_row_end_r <= s1_last_col_r;
      out_img_end_r <= s1_last_col_r && s1_last_row_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_row_end_r;
  assign out_tuser[0] = out_img_end_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(line_wr && line_rd))
    else $error("line buffer read and written in one cycle");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    x_r <= wlim_r.last)
    else $error("column position beyond image width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    y_r <= hlim_r.last)
    else $error("row position beyond image height");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |=> s1_valid_r && $stable(s1_pair_r))
    else $error("compute stage lost its item under stall");

  a_img_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("image end without row end");

endmodule
`default_nettype wire

// ===== tb/sv/tb_rgba_box_downsample_2x2_core.sv =====
// self-checking testbench for the rgba 2x2 box-filter downsampler core
module tb_rgba_box_downsample_2x2_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W       = rbd_pkg::CH_W;
  localparam int NUM_CH     = rbd_pkg::NUM_CH;
  localparam int PIX_W      = rbd_pkg::PIX_W;
  localparam int DIM_W      = rbd_pkg::DIM_W;
  localparam int LSUM_W     = rbd_pkg::LSUM_W;
  localparam int CFG_AW     = rbd_pkg::CFG_AW;
  localparam int LINE_DEPTH = rbd_pkg::LINE_DEPTH;
  localparam int MAX_WIDTH  = rbd_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = rbd_pkg::MAX_HEIGHT;

  typedef rbd_pkg::dim_t dim_t;

  // one rgba8 pixel, red in the lowest byte as on in_tdata / out_tdata
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgba_t;

  // one averaged output pixel with its position flags
  typedef struct {
    rgba_t pix;
    bit    row_end;
    bit    image_end;
  } avg_pixel_t;

  localparam int SETTLE_CYCLES  = 8;     // covers the compute and output registers plus margin
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either side
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_ITEMS   = 1400;

  // clock, reset and block ports
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [PIX_W-1:0]  out_tdata;
  logic              out_tlast;
  logic [0:0]        out_tuser;
  logic              cfg_we     = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [DIM_W-1:0]  cfg_wdata  = '0;

  // idling controls, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holdoff_left   = 0;  // receiver hold-off, counted down in its own process

  // bookkeeping
  int n_errors       = 0;
  int n_pixels_in    = 0;
  int n_pixels_out   = 0;
  int n_settings     = 0;
  int idle_cycles    = 0;

  // predictor state: size registers, raster position, held left pixel, pair sums
  dim_t              width_reg;
  dim_t              height_reg;
  int                col_pos;
  int                row_pos;
  logic [PIX_W-1:0]  held_pixel;
  logic [LSUM_W-1:0] pair_line [LINE_DEPTH][NUM_CH];
  avg_pixel_t        expected_pixels [$];

  rgba_box_downsample_2x2_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // red, green, blue, alpha
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_red, out_green, out_blue, out_alpha
    .out_tlast  (out_tlast),  // row_end
    .out_tuser  (out_tuser),  // image_end
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // zero means one, anything past the maximum saturates
  function automatic int eff_dim(input dim_t v, input int max_v);
    if (v == '0) return 1;
    if (int'(v) > max_v) return max_v;
    return int'(v);
  endfunction

  // a size write restarts the image at column 0, row 0
  function automatic void apply_size_write(input logic [CFG_AW-1:0] idx, input dim_t val);
    if (idx == rbd_pkg::REG_IMAGE_WIDTH) width_reg = val;
    else if (idx == rbd_pkg::REG_IMAGE_HEIGHT) height_reg = val;
    col_pos    = 0;
    row_pos    = 0;
    held_pixel = '0;
  endfunction

  function automatic void reset_downsample_model();
    width_reg  = DIM_W'(2);
    height_reg = DIM_W'(2);
    col_pos    = 0;
    row_pos    = 0;
    held_pixel = '0;
  endfunction

  // advance the raster position by one source pixel and queue the averaged
  // pixel if this one completes a 2x2 block
  function automatic void predict_downsample(input rgba_t px);
    int               w, h, x, y, idx, c;
    int               pair_sum [NUM_CH];
    int               block_sum [NUM_CH];
    logic [PIX_W-1:0] cur, acc;
    bit               have_pair, last_col, last_row, emit;
    avg_pixel_t       res;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    x = col_pos;
    y = row_pos;
    cur = px;
    idx = 0;
    have_pair = 0;
    last_col  = 0;
    last_row  = 0;
    emit      = 0;
    // horizontal pair: single column counts twice, odd last column is dropped
    if (w == 1) begin
      for (c = 0; c < NUM_CH; c++) pair_sum[c] = 2 * int'(cur[CH_W*c +: CH_W]);
      have_pair = 1;
      last_col  = 1;
    end else if (x < (w / 2) * 2) begin
      if (x % 2 == 0) begin
        held_pixel = cur;
      end else begin
        for (c = 0; c < NUM_CH; c++)
          pair_sum[c] = int'(held_pixel[CH_W*c +: CH_W]) + int'(cur[CH_W*c +: CH_W]);
        have_pair = 1;
        idx       = x / 2;
        last_col  = (x == (w / 2) * 2 - 1);
      end
    end
    // vertical pair: a single row counts twice, else even rows store, odd rows add and emit
    if (have_pair) begin
      if (h == 1) begin
        for (c = 0; c < NUM_CH; c++) block_sum[c] = 2 * pair_sum[c];
        emit     = 1;
        last_row = 1;
      end else if (y < (h / 2) * 2) begin
        if (y % 2 == 0) begin
          for (c = 0; c < NUM_CH; c++) pair_line[idx][c] = pair_sum[c][LSUM_W-1:0];
        end else begin
          for (c = 0; c < NUM_CH; c++) block_sum[c] = int'(pair_line[idx][c]) + pair_sum[c];
          emit     = 1;
          last_row = (y == (h / 2) * 2 - 1);
        end
      end
    end
    if (emit) begin
      acc = '0;
      for (c = 0; c < NUM_CH; c++) acc[CH_W*c +: CH_W] = CH_W'((block_sum[c] + 2) / 4);
      res.pix       = acc;
      res.row_end   = last_col;
      res.image_end = last_col && last_row;
      expected_pixels.insert(expected_pixels.size(), res);
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endfunction

  // ------------------------------------------------------------------
  // result side: random stalls, hold-off, checking
  // ------------------------------------------------------------------

  // receiver readiness; a pending hold-off wins over the random stalls
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < MAX_REPORTS)
      $display("[%0t] averaged pixel %0d: %s is %0h, expected %0h",
               $realtime, n_pixels_out, what, got, want);
    n_errors++;
  endtask

  // every out_ transfer is compared with the oldest queued average
  always @(posedge clk) begin : check_results
    avg_pixel_t want;
    rgba_t      got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_pixels.size() == 0) begin
        report_mismatch("transfer with nothing expected", got, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.pix.red)     report_mismatch("out_red", got.red, want.pix.red);
        if (got.green !== want.pix.green) report_mismatch("out_green", got.green, want.pix.green);
        if (got.blue !== want.pix.blue)   report_mismatch("out_blue", got.blue, want.pix.blue);
        if (got.alpha !== want.pix.alpha) report_mismatch("out_alpha", got.alpha, want.pix.alpha);
        if (out_tlast !== want.row_end)   report_mismatch("row_end", out_tlast, want.row_end);
        if (out_tuser[0] !== want.image_end)
          report_mismatch("image_end", out_tuser[0], want.image_end);
      end
      n_pixels_out++;
    end
  end

  // watchdog: a stretch with no transfer on either side means the block hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // source side
  // ------------------------------------------------------------------

  // channels lean toward the extremes so both ends of every field show up often
  function automatic rgba_t random_pixel();
    logic [PIX_W-1:0] bits;
    int               c;
    for (c = 0; c < NUM_CH; c++) begin
      case ($urandom_range(9))
        0:       bits[CH_W*c +: CH_W] = '0;
        1:       bits[CH_W*c +: CH_W] = '1;
        default: bits[CH_W*c +: CH_W] = CH_W'($urandom);
      endcase
    end
    return bits;
  endfunction

  // offer one pixel and hold it until the transfer; predict at acceptance
  task automatic send_pixel(input rgba_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_downsample(px);
    n_pixels_in++;
  endtask

  task automatic send_pixels(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // stop offering and wait until every queued average has come out
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // drained and quiet: pixels that make no average may still be in flight
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both size registers, written back to back while the block is idle
  task automatic set_size(input dim_t w, input dim_t h);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= rbd_pkg::REG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    apply_size_write(rbd_pkg::REG_IMAGE_WIDTH, w);
    cfg_addr  <= rbd_pkg::REG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    apply_size_write(rbd_pkg::REG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic int image_pixels();
    return eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
  endfunction

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // black, white, rounding, zero sizes and dropped edges
  task automatic test_directed_corners();
    set_idling(0, 0);
    set_size(DIM_W'(2), DIM_W'(2));
    repeat (4) send_pixel('0);
    repeat (4) send_pixel('1);
    // per channel block sums 1, 2, 5 and 1019: round down, up, down, to full
    send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'hff});
    send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h01, alpha: 8'hff});
    send_pixel('{red: 8'h00, green: 8'h01, blue: 8'h02, alpha: 8'hff});
    send_pixel('{red: 8'h01, green: 8'h01, blue: 8'h02, alpha: 8'hfe});
    // zero width and height read as one, the lone pixel counts four times
    set_size(DIM_W'(0), DIM_W'(0));
    send_pixel('{red: 8'h01, green: 8'h7f, blue: 8'h80, alpha: 8'hfe});
    send_pixel(random_pixel());
    // odd last column and row are consumed without output
    set_size(DIM_W'(3), DIM_W'(3));
    send_pixels(9);
  endtask

  // a size write in the middle of an image starts over at the top left
  task automatic test_restart_on_write();
    set_idling(13, 13);
    set_size(DIM_W'(4), DIM_W'(2));
    send_pixels(3);
    set_size(DIM_W'(4), DIM_W'(2));
    send_pixels(8);
    set_size(DIM_W'(6), DIM_W'(4));
    send_pixels(15);
    set_size(DIM_W'(6), DIM_W'(4));
    send_pixels(24);
  endtask

  // counts wrap after the last pixel, so images follow without a write
  task automatic test_back_to_back_images();
    set_idling(0, 0);
    set_size(DIM_W'(4), DIM_W'(4));
    send_pixels(3 * image_pixels());
    set_size(DIM_W'(5), DIM_W'(1));
    send_pixels(2 * image_pixels());
    set_size(DIM_W'(1), DIM_W'(5));
    send_pixels(2 * image_pixels());
    set_size(DIM_W'(1), DIM_W'(1));
    send_pixels(6);
  endtask

  // widest and tallest sizes, only for their first pixels
  task automatic test_extreme_sizes();
    set_idling(13, 13);
    set_size(DIM_W'(8191), DIM_W'(1));  // saturates to the maximum width
    send_pixels(64);
    set_size(DIM_W'(MAX_WIDTH), DIM_W'(1));
    send_pixels(64);
    set_size(DIM_W'(2), DIM_W'(8191));  // saturates to the maximum height
    send_pixels(40);
    set_size(DIM_W'(1), DIM_W'(MAX_HEIGHT));
    send_pixels(40);
    set_size(DIM_W'(4097), DIM_W'(4097));
    send_pixels(32);
  endtask

  // long receiver hold-off while the sender keeps offering, so in_tready drops
  task automatic test_output_holdoff();
    set_idling(0, 0);
    set_size(DIM_W'(6), DIM_W'(4));
    holdoff_left = 300;
    send_pixels(3 * image_pixels());
  endtask

  // sender stops mid-image until every average is out, then goes on
  task automatic test_sender_pause();
    set_idling(13, 13);
    set_size(DIM_W'(8), DIM_W'(6));
    send_pixels(20);
    wait_for_results();
    send_pixels(image_pixels() - 20);
    wait_for_results();
    send_pixels(image_pixels() + 11);
  endtask

  // random sizes, mostly small, whole images with some cut short
  task automatic test_random_images(input int send_pct, input int recv_pct, input int items);
    int   sent, n, r;
    dim_t w, h;
    set_idling(send_pct, recv_pct);
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      if (r < 5)       w = '0;
      else if (r < 12) w = DIM_W'($urandom_range(13, 40));
      else             w = DIM_W'($urandom_range(1, 10));
      r = $urandom_range(99);
      if (r < 5)       h = '0;
      else if (r < 10) h = DIM_W'($urandom_range(9, 16));
      else             h = DIM_W'($urandom_range(1, 8));
      set_size(w, h);
      if ($urandom_range(99) < 15) n = $urandom_range(1, image_pixels());
      else                         n = $urandom_range(1, 3) * image_pixels();
      if (n > items - sent) n = items - sent;
      send_pixels(n);
      sent += n;
    end
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    reset_downsample_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_restart_on_write();
    test_back_to_back_images();
    test_extreme_sizes();
    test_output_holdoff();
    test_sender_pause();
    test_random_images(0, 0, RANDOM_ITEMS / 4);
    test_random_images(55, 0, RANDOM_ITEMS / 4);
    test_random_images(0, 55, RANDOM_ITEMS / 4);
    test_random_images(13, 13, RANDOM_ITEMS / 4);
    settle();

    $display("covered %0d source pixels and %0d averaged pixels over %0d size settings",
             n_pixels_in, n_pixels_out, n_settings);
    $display("idling: none, sender only, receiver only, both; plus hold-off and drained pause");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
